// ===== sv/sliding_window_variance_decimated_top_assert.svh =====
`ifndef SLIDING_WINDOW_VARIANCE_DECIMATED_TOP_ASSERT_SVH
`define SLIDING_WINDOW_VARIANCE_DECIMATED_TOP_ASSERT_SVH

// Condition must never hold on a clock edge outside reset.
`define SWV_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SWV_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/swv_pkg.sv =====
package swv_pkg;

    localparam int FIELD_W     = 16;
    localparam int TDATA_W     = 64;
    localparam int RESULT_W    = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int WL_W        = 8;
    localparam int DEC_W       = 8;
    localparam int LANES_CFG_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LANES         = 2'd2;

    localparam logic [WL_W-1:0]        WL_RESET    = 8'd120;
    localparam logic [DEC_W-1:0]       DEC_RESET   = 8'd12;
    localparam logic [LANES_CFG_W-1:0] LANES_RESET = 3'd3;

    typedef struct packed {
        logic clear;
        logic sq_en;
        logic acc_en;
        logic drop_old;
        logic prod_en;
        logic num_en;
    } lane_ctl_t;

endpackage

// ===== sv/swv_ram.sv =====
module swv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/swv_lane.sv =====
module swv_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 128,
    localparam int LOG_W      = $clog2(MAX_WINDOW),
    localparam int N_W        = $clog2(MAX_WINDOW + 1),
    localparam int SQ_W       = 2 * SAMPLE_BITS - 1 + LOG_W,
    localparam int NUM_W      = N_W + SQ_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swv_pkg::lane_ctl_t            ctl,
    input  logic signed [SAMPLE_BITS-1:0] new_sample,
    input  logic signed [SAMPLE_BITS-1:0] old_sample,
    input  logic [N_W-1:0]                n,
    output logic [NUM_W-1:0]              num
);

    localparam int SUM_W = SAMPLE_BITS + LOG_W;
    localparam int PSQ_W = 2 * SAMPLE_BITS - 1;

    logic signed [SUM_W-1:0]         sum_reg, sum_next;
    logic [SQ_W-1:0]                 sq_reg, sq_next;
    logic [PSQ_W-1:0]                new_sq_reg, old_sq_reg;
    logic signed [2*SAMPLE_BITS-1:0] new_prod, old_prod;
    logic signed [SUM_W-1:0]         new_ext, old_ext;
    logic [NUM_W-1:0]                nsq_full, nsq_reg, ssq_reg, num_reg;
    logic signed [2*SUM_W-1:0]       sum_sq_full;

    assign new_prod = (2*SAMPLE_BITS)'(new_sample) * (2*SAMPLE_BITS)'(new_sample);
    assign old_prod = (2*SAMPLE_BITS)'(old_sample) * (2*SAMPLE_BITS)'(old_sample);
    assign new_ext  = {{(SUM_W-SAMPLE_BITS){new_sample[SAMPLE_BITS-1]}}, new_sample};
    assign old_ext  = {{(SUM_W-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};

    always_comb begin
        sum_next = sum_reg + new_ext - (ctl.drop_old ? old_ext : '0);
        sq_next  = sq_reg + SQ_W'(new_sq_reg) - (ctl.drop_old ? SQ_W'(old_sq_reg) : '0);
    end

    // n*sumsq >= sum^2 for a full window, so the difference never wraps
    assign nsq_full    = NUM_W'(n) * NUM_W'(sq_reg);
    assign sum_sq_full = (2*SUM_W)'(sum_reg) * (2*SUM_W)'(sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (ctl.clear) begin
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (ctl.acc_en) begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sq_en) begin
            new_sq_reg <= new_prod[PSQ_W-1:0];
            old_sq_reg <= old_prod[PSQ_W-1:0];
        end
        if (ctl.prod_en) begin
            nsq_reg <= nsq_full;
            ssq_reg <= sum_sq_full[NUM_W-1:0];
        end
        if (ctl.num_en) begin
            num_reg <= nsq_reg - ssq_reg;
        end
    end

    assign num = num_reg;

endmodule

// ===== sv/swv_div.sv =====
module swv_div #(
    parameter int DIVIDEND_W = 48,
    parameter int DIVISOR_W  = 16,
    localparam int Q_W       = swv_pkg::RESULT_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [Q_W-1:0]        quotient
);

    localparam int EXT_W = (DIVIDEND_W > Q_W) ? DIVIDEND_W : Q_W + 1;
    localparam int HI_W  = EXT_W - Q_W;
    localparam int CMP_W = (HI_W > DIVISOR_W) ? HI_W : DIVISOR_W;
    localparam int CNT_W = $clog2(Q_W);

    logic [EXT_W-1:0]     ext;
    logic [HI_W-1:0]      hi;
    logic                 sat;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [Q_W-1:0]       q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign ext = EXT_W'(dividend);
    assign hi  = ext[EXT_W-1:Q_W];
    // quotient would not fit in Q_W bits
    assign sat = CMP_W'(hi) >= CMP_W'(divisor);

    assign trial = {rem_reg, q_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIVISOR_W'(hi);
            q_reg   <= sat ? '1 : ext[Q_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, divisor}) : DIVISOR_W'(trial);
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/sliding_window_variance_decimated_top.sv =====
// Trailing-window variance over up to four lanes, one result every decimation-th frame.
// A frame is accepted only in idle; it passes CLR, RD, SQ and ACC, and returns to idle
// unless it gives a result. A result frame then runs PROD, NUM, MERGE, the 32-step serial
// divider (one quotient bit per cycle, skipped if the result saturates) and OUT, where an
// output stall holds it; if the window is not full it goes straight to OUT with a zero result.
// The next frame waits until the state returns to idle. Reset (aresetn low, synchronous): registers to
// 120/12/3, sums and counters cleared, no result pending; the window store is not cleared.
module sliding_window_variance_decimated_top #(
    parameter int MAX_WINDOW  = 128,
    parameter int LANES       = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swv_pkg::TDATA_W-1:0]      s_tdata,   // sample_a, sample_b, sample_c, sample_d
    input  logic                             s_tuser,   // stream_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swv_pkg::RESULT_W-1:0]     m_tdata,   // variance
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swv_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int N_W    = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + AW;
    localparam int NUM_W  = N_W + SQ_W;
    localparam int TOT_W  = NUM_W + $clog2(LANES);
    localparam int D_W    = 2 * N_W;
    localparam int LN_W   = $clog2(LANES + 1);
    localparam int RAM_W  = LANES * SAMPLE_BITS;
    localparam int DIFF_W = N_W + 1;
    localparam int DEC_W  = swv_pkg::DEC_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_ACC   = 4'd4;
    localparam logic [3:0] ST_PROD  = 4'd5;
    localparam logic [3:0] ST_NUM   = 4'd6;
    localparam logic [3:0] ST_MERGE = 4'd7;
    localparam logic [3:0] ST_DIVS  = 4'd8;
    localparam logic [3:0] ST_DIVW  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;

    logic [swv_pkg::WL_W-1:0]        wl_reg;
    logic [DEC_W-1:0]                dec_reg;
    logic [swv_pkg::LANES_CFG_W-1:0] lanes_reg;

    logic [N_W-1:0]   n_eff;
    logic [LN_W-1:0]  lanes_eff;
    logic [DEC_W-1:0] dec_eff;

    logic [LANES-1:0][SAMPLE_BITS-1:0] samp_in, samp_reg;
    logic                              start_reg;
    logic                              full_reg;

    logic [N_W-1:0]   fc_reg, fc_next;
    logic [N_W:0]     fc_inc;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [DEC_W-1:0] dc_reg, dc_next;
    logic [DEC_W:0]   dc_inc;

    logic [DIFF_W-1:0] diff, old_full;
    logic [AW-1:0]     old_addr;
    logic              ram_we, ram_re;
    logic [RAM_W-1:0]  ram_rdata;

    swv_pkg::lane_ctl_t           lane_ctl;
    logic [LANES-1:0][NUM_W-1:0]  lane_num;
    logic [TOT_W-1:0]             total_sum, total_reg;
    logic [D_W-1:0]               n_sq, dsq_reg;

    logic                          div_start, div_done;
    logic [swv_pkg::RESULT_W-1:0]  div_q, result_reg, m_tdata_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          load_out;
    logic                          wl_clear;

    // effective register values
    always_comb begin
        if (wl_reg == '0) begin
            n_eff = N_W'(1);
        end else if (32'(wl_reg) > MAX_WINDOW) begin
            n_eff = N_W'(MAX_WINDOW);
        end else begin
            n_eff = N_W'(wl_reg);
        end
        if (lanes_reg == '0) begin
            lanes_eff = LN_W'(1);
        end else if (32'(lanes_reg) > LANES) begin
            lanes_eff = LN_W'(LANES);
        end else begin
            lanes_eff = LN_W'(lanes_reg);
        end
        dec_eff = (dec_reg == '0) ? DEC_W'(1) : dec_reg;
    end

    // low SAMPLE_BITS of each field; bits above the field read as zero
    for (genvar k = 0; k < LANES; k++) begin : g_samp
        for (genvar i = 0; i < SAMPLE_BITS; i++) begin : g_bit
            if (i < swv_pkg::FIELD_W) begin : g_in
                assign samp_in[k][i] = s_tdata[swv_pkg::FIELD_W * k + i];
            end else begin : g_zero
                assign samp_in[k][i] = 1'b0;
            end
        end
    end

    // oldest sample in the window: (wp - n) mod MAX_WINDOW
    always_comb begin
        diff     = DIFF_W'(wp_reg) - DIFF_W'(n_eff);
        old_full = diff[DIFF_W-1] ? diff + DIFF_W'(MAX_WINDOW) : diff;
        old_addr = old_full[AW-1:0];
    end

    assign fc_inc = {1'b0, fc_reg} + 1'b1;
    assign dc_inc = {1'b0, dc_reg} + 1'b1;
    assign n_sq   = D_W'(n_eff) * D_W'(n_eff);

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign wl_clear  = cfg_valid && cfg_ready && (cfg_index == swv_pkg::REG_WINDOW_LENGTH);

    always_comb begin
        state_next = state_reg;
        fc_next    = fc_reg;
        wp_next    = wp_reg;
        dc_next    = dc_reg;
        lane_ctl   = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR: begin
                if (start_reg) begin
                    lane_ctl.clear = 1'b1;
                    fc_next        = '0;
                    wp_next        = '0;
                    dc_next        = '0;
                end
                state_next = ST_RD;
            end
            ST_RD: begin
                ram_re     = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                lane_ctl.sq_en = 1'b1;
                ram_we         = 1'b1;
                state_next     = ST_ACC;
            end
            ST_ACC: begin
                lane_ctl.acc_en   = 1'b1;
                lane_ctl.drop_old = full_reg;
                wp_next = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (!full_reg) begin
                    fc_next = fc_inc[N_W-1:0];
                end
                if (dc_inc < {1'b0, dec_eff}) begin
                    dc_next    = dc_inc[DEC_W-1:0];
                    state_next = ST_IDLE;
                end else begin
                    dc_next = '0;
                    if (full_reg || (fc_inc >= {1'b0, n_eff})) begin
                        state_next = ST_PROD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PROD: begin
                lane_ctl.prod_en = 1'b1;
                state_next       = ST_NUM;
            end
            ST_NUM: begin
                lane_ctl.num_en = 1'b1;
                state_next      = ST_MERGE;
            end
            ST_MERGE: begin
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                div_start  = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (wl_clear) begin
            lane_ctl.clear = 1'b1;
            fc_next        = '0;
            wp_next        = '0;
        end
        m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    // merge: sum of per-lane numerators over the lanes in use
    always_comb begin
        total_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            if (k < 32'(lanes_eff)) begin
                total_sum = total_sum + TOT_W'(lane_num[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fc_reg       <= '0;
            wp_reg       <= '0;
            dc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            wl_reg       <= swv_pkg::WL_RESET;
            dec_reg      <= swv_pkg::DEC_RESET;
            lanes_reg    <= swv_pkg::LANES_RESET;
        end else begin
            state_reg    <= state_next;
            fc_reg       <= fc_next;
            wp_reg       <= wp_next;
            dc_reg       <= dc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    swv_pkg::REG_WINDOW_LENGTH: wl_reg    <= cfg_data;
                    swv_pkg::REG_DECIMATION:    dec_reg   <= cfg_data;
                    swv_pkg::REG_LANES:         lanes_reg <= cfg_data[swv_pkg::LANES_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            samp_reg  <= samp_in;
            start_reg <= s_tuser;
        end
        if (state_reg == ST_RD) begin
            full_reg <= (fc_reg >= n_eff);
        end
        if (state_reg == ST_ACC) begin
            result_reg <= '0;
        end
        if (state_reg == ST_PROD) begin
            dsq_reg <= n_sq;
        end
        if (state_reg == ST_MERGE) begin
            total_reg <= total_sum;
        end
        if ((state_reg == ST_DIVW) && div_done) begin
            result_reg <= div_q;
        end
        if (load_out) begin
            m_tdata_reg <= result_reg;
        end
    end

    swv_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (samp_reg),
        .re    (ram_re),
        .raddr (old_addr),
        .rdata (ram_rdata)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        swv_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .MAX_WINDOW  (MAX_WINDOW)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (lane_ctl),
            .new_sample (samp_reg[k]),
            .old_sample (ram_rdata[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .n          (n_eff),
            .num        (lane_num[k])
        );
    end

    swv_div #(
        .DIVIDEND_W (TOT_W),
        .DIVISOR_W  (D_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (dsq_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "sliding_window_variance_decimated_top_assert.svh"

    `SWV_NEVER(a_fc_bound, fc_reg > n_eff, "frame count above window length")
    `SWV_IMPLIES(a_dec_restart, state_reg == ST_OUT, dc_reg == '0, "result without decimation restart")
    `SWV_IMPLIES(a_div_done, div_done, state_reg == ST_DIVW, "divider finished outside its wait state")

endmodule
